/* hw/rtl/rcw_pkg.sv */
// Shared types and constants for the Reno congestion window controller.
// Used by rcw_divider and reno_congestion_window_top; no dependencies.
`default_nettype none

package rcw_pkg;

  // Event kinds on the input channel.
  localparam logic OP_ACK     = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Congestion control phases.
  localparam logic [1:0] PHASE_SLOW_START = 2'd0;
  localparam logic [1:0] PHASE_AVOIDANCE  = 2'd1;
  localparam logic [1:0] PHASE_RECOVERY   = 2'd2;

  // Configuration register indexes.
  localparam logic REG_INITIAL_THRESHOLD = 1'b0;
  localparam logic REG_MINIMUM_THRESHOLD = 1'b1;

  localparam int THR_W  = 13;
  localparam int FRAC_W = 16;

  localparam logic [THR_W-1:0] INITIAL_THRESHOLD_RESET = 13'd128;
  localparam logic [THR_W-1:0] MINIMUM_THRESHOLD_RESET = 13'd32;
  localparam logic [THR_W-1:0] THRESH_CAP              = 13'd8191;

  localparam logic [7:0] DUP_TRIGGER = 8'd3;
  localparam logic [7:0] DUP_CAP     = 8'd255;

  // One packet in Q.16, and the divider operand widths.
  localparam logic [16:0] ONE_PACKET = 17'h10000;
  localparam int DIV_NUM_W = 18;
  localparam int DIV_DEN_W = 17;

  typedef struct packed {
    logic        operation;
    logic [31:0] ack_number;
  } event_t;

  typedef struct packed {
    logic [31:0]      window_base;
    logic [31:0]      window_end;
    logic             retransmit;
    logic [31:0]      retransmit_number;
    logic [1:0]       phase;
    logic [THR_W-1:0] window_whole;
    logic             stale;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/rcw_divider.sv */
// Restoring integer divider, one quotient bit per cycle.
// Depends on rcw_pkg for operand widths and the request/response structs.
`default_nettype none

module rcw_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rcw_pkg::div_req_t req,
  output rcw_pkg::div_rsp_t      rsp
);

  localparam int NUM_W = rcw_pkg::DIV_NUM_W;
  localparam int DEN_W = rcw_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;

  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    fits     = trial >= {1'b0, den};
    rem_next = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem   <= '0;
        quo   <= req.num;
        den   <= req.den;
        count <= CNT_W'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= rem_next;
        quo   <= {quo[NUM_W-2:0], fits};
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

/* hw/rtl/reno_congestion_window_top.sv */
// Top level of the Reno congestion window controller.
// Depends on rcw_pkg and instantiates rcw_divider.
//
// Usage: each transfer on the event channel is either a cumulative ack
// (operation = ack) or a retransmit timer expiry (operation = timeout). For
// every event exactly one result transfer follows on the result channel,
// carrying the send window, the retransmit request, the phase, the whole
// window and a stale flag for acks that fell below the last ack.
// The block works on one event at a time: event_ready is high only while
// the sequencer is idle. A timeout, a duplicate ack or a stale ack goes
// straight from idle to the completion state, which loads the output
// register. A new ack walks the newly acked packets: slow start passes
// through a plan and an apply state, and congestion avoidance takes two
// passes through the shared 18-bit divider and a registered 32x17
// multiply for every whole packet the window crosses, and one divider
// pass and the multiply for the final partial step.
// The result sits in an output register, so the next event is taken while
// an earlier result still waits for result_ready; if the receiver stalls
// longer, the sequencer holds the finished result until the register frees.
// Reset is synchronous: window one packet, slow start, threshold and the
// minimum threshold at their defaults, last ack zero. The configuration
// port writes one register per cycle with cfg_write; writing the initial
// threshold also reloads the working threshold.
`default_nettype none

module reno_congestion_window_top #(
  parameter int MAX_WINDOW = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     event_valid,
  output logic                          event_ready,
  input  wire rcw_pkg::event_t          event_item,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  output rcw_pkg::result_t              result_item,
  input  wire logic                     cfg_write,
  input  wire logic                     cfg_index,
  input  wire logic [rcw_pkg::THR_W-1:0] cfg_data
);

  // The window register holds whole packets up to MAX_WINDOW plus 16
  // fraction bits; the working width covers the threshold in Q.16 as well.
  localparam int WHOLE_W = $clog2(MAX_WINDOW) + 1;
  localparam int WIN_W   = WHOLE_W + rcw_pkg::FRAC_W;
  localparam int CALC_W  = ((WIN_W > 29) ? WIN_W : 29) + 2;
  localparam int PROD_W  = 32 + rcw_pkg::DIV_DEN_W;

  localparam logic [CALC_W-1:0] ONE_C   = CALC_W'(rcw_pkg::ONE_PACKET);
  localparam logic [CALC_W-1:0] THREE_C = CALC_W'(3) << rcw_pkg::FRAC_W;
  localparam logic [CALC_W-1:0] MAX_C   = CALC_W'(MAX_WINDOW) << rcw_pkg::FRAC_W;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_LOOP      = 4'd1;
  localparam logic [3:0] ST_SS_PLAN   = 4'd2;
  localparam logic [3:0] ST_SS_APPLY  = 4'd3;
  localparam logic [3:0] ST_INC_WAIT  = 4'd4;
  localparam logic [3:0] ST_CA_MUL    = 4'd5;
  localparam logic [3:0] ST_CA_CMP    = 4'd6;
  localparam logic [3:0] ST_NEED_WAIT = 4'd7;
  localparam logic [3:0] ST_NEED_MUL  = 4'd8;
  localparam logic [3:0] ST_NEED_ADD  = 4'd9;
  localparam logic [3:0] ST_DONE      = 4'd10;

  // Control state.
  logic [3:0]                state;
  logic [WIN_W-1:0]          window_fixed;
  logic [1:0]                phase_reg;
  logic [rcw_pkg::THR_W-1:0] threshold;
  logic [rcw_pkg::THR_W-1:0] minimum_threshold;
  logic [7:0]                duplicate_count;
  logic [31:0]               last_ack;

  // Working registers of the ack walk.
  logic [31:0]                    remaining;
  logic [rcw_pkg::THR_W-1:0]      ss_steps;
  logic [rcw_pkg::DIV_DEN_W-1:0]  increment;
  logic [rcw_pkg::DIV_NUM_W-1:0]  need;
  logic [PROD_W-1:0]              product;
  logic                           resend;
  logic                           stale_flag;

  rcw_pkg::div_req_t div_req;
  rcw_pkg::div_rsp_t div_rsp;

  function automatic logic [WIN_W-1:0] clamp_win(input logic [CALC_W-1:0] v);
    logic [CALC_W-1:0] r;
    r = v;
    if (r > MAX_C) r = MAX_C;
    if (r < ONE_C) r = ONE_C;
    return r[WIN_W-1:0];
  endfunction

  // Threshold after a loss: half the whole window, bounded below by the
  // minimum register and above by the threshold cap.
  function automatic logic [rcw_pkg::THR_W-1:0] halved(
    input logic [WHOLE_W-1:0]        wh,
    input logic [rcw_pkg::THR_W-1:0] lo
  );
    logic [17:0] h;
    h = 18'(wh) >> 1;
    if (h < 18'(lo)) h = 18'(lo);
    if (h > 18'(rcw_pkg::THRESH_CAP)) h = 18'(rcw_pkg::THRESH_CAP);
    return h[rcw_pkg::THR_W-1:0];
  endfunction

  logic [CALC_W-1:0]              win_c;
  logic [WHOLE_W-1:0]             whole;
  logic [CALC_W-1:0]              goal;
  logic [rcw_pkg::THR_W-1:0]      loss_thr;
  logic [WIN_W-1:0]               timeout_win;
  logic [7:0]                     dup_next;
  logic                           dup_trigger;
  logic [WIN_W-1:0]               dup_win;
  logic [CALC_W-1:0]              ss_gap;
  logic [rcw_pkg::THR_W-1:0]      ss_need;
  logic [rcw_pkg::THR_W-1:0]      ss_pick;
  logic [WIN_W-1:0]               ss_win;
  logic [CALC_W-1:0]              ca_next;
  logic [rcw_pkg::DIV_DEN_W-1:0]  ca_gap;
  logic                           ca_small;
  logic [WIN_W-1:0]               ca_win;
  logic [31:0]                    mul_a;
  logic [31:0]                    base;
  rcw_pkg::result_t               result_next;

  always_comb begin
    win_c = CALC_W'(window_fixed);
    whole = window_fixed[WIN_W-1:rcw_pkg::FRAC_W];
    goal  = CALC_W'(threshold) << rcw_pkg::FRAC_W;

    // Timeout and third duplicate share the halved threshold.
    loss_thr    = halved(whole, minimum_threshold);
    timeout_win = clamp_win(CALC_W'(loss_thr >> 1) << rcw_pkg::FRAC_W);

    dup_next    = (duplicate_count < rcw_pkg::DUP_CAP) ? duplicate_count + 8'd1
                                                       : duplicate_count;
    dup_trigger = (phase_reg != rcw_pkg::PHASE_RECOVERY) &&
                  (dup_next == rcw_pkg::DUP_TRIGGER);
    if (phase_reg == rcw_pkg::PHASE_RECOVERY) begin
      dup_win = clamp_win(win_c + ONE_C);
    end else if (dup_trigger) begin
      dup_win = clamp_win(win_c + THREE_C);
    end else begin
      dup_win = window_fixed;
    end

    // Slow start: packets still needed to reach the threshold, rounded up.
    ss_gap  = goal - win_c + (ONE_C - CALC_W'(1));
    ss_need = (win_c < goal) ? rcw_pkg::THR_W'(ss_gap >> rcw_pkg::FRAC_W)
                             : rcw_pkg::THR_W'(1);
    ss_pick = (remaining < 32'(ss_need)) ? remaining[rcw_pkg::THR_W-1:0] : ss_need;
    ss_win  = clamp_win(win_c + (CALC_W'(ss_steps) << rcw_pkg::FRAC_W));

    // Congestion avoidance: distance to the next whole packet. If all the
    // remaining acks fall short of it, they are applied in one go.
    ca_next  = (CALC_W'(whole) + CALC_W'(1)) << rcw_pkg::FRAC_W;
    ca_gap   = rcw_pkg::DIV_DEN_W'(ca_next - win_c);
    ca_small = product < PROD_W'(ca_gap);
    ca_win   = clamp_win(win_c + CALC_W'(product));

    mul_a = (state == ST_NEED_MUL) ? 32'(need) : remaining;

    div_req.start = ((state == ST_LOOP) && (remaining != 32'd0) &&
                     (phase_reg == rcw_pkg::PHASE_AVOIDANCE) && (win_c < MAX_C)) ||
                    ((state == ST_CA_CMP) && !ca_small);
    if (state == ST_CA_CMP) begin
      div_req.num = rcw_pkg::DIV_NUM_W'(ca_gap) + rcw_pkg::DIV_NUM_W'(increment)
                    - rcw_pkg::DIV_NUM_W'(1);
      div_req.den = increment;
    end else begin
      div_req.num = rcw_pkg::DIV_NUM_W'(rcw_pkg::ONE_PACKET);
      div_req.den = rcw_pkg::DIV_DEN_W'(whole);
    end

    base = last_ack + 32'd1;
    result_next.window_base       = base;
    result_next.window_end        = base + 32'(whole) - 32'd1;
    result_next.retransmit        = resend;
    result_next.retransmit_number = resend ? base : 32'd0;
    result_next.phase             = phase_reg;
    result_next.window_whole      = rcw_pkg::THR_W'(whole);
    result_next.stale             = stale_flag;
  end

  rcw_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Shared multiplier with its result register.
  always_ff @(posedge clk) begin
    product <= PROD_W'(mul_a) * PROD_W'(increment);
  end

  assign event_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      window_fixed      <= WIN_W'(rcw_pkg::ONE_PACKET);
      phase_reg         <= rcw_pkg::PHASE_SLOW_START;
      threshold         <= rcw_pkg::INITIAL_THRESHOLD_RESET;
      minimum_threshold <= rcw_pkg::MINIMUM_THRESHOLD_RESET;
      duplicate_count   <= 8'd1;
      last_ack          <= 32'd0;
      result_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rcw_pkg::REG_INITIAL_THRESHOLD: begin
            threshold <= cfg_data;
          end
          rcw_pkg::REG_MINIMUM_THRESHOLD: begin
            minimum_threshold <= cfg_data;
          end
          default: ;
        endcase
      end

      // The completion state reloads the output register itself.
      if (result_valid && result_ready && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (event_valid) begin
            resend     <= 1'b0;
            stale_flag <= 1'b0;
            state      <= ST_DONE;
            if (event_item.operation == rcw_pkg::OP_TIMEOUT) begin
              threshold       <= loss_thr;
              window_fixed    <= timeout_win;
              duplicate_count <= 8'd1;
              phase_reg       <= rcw_pkg::PHASE_SLOW_START;
              resend          <= 1'b1;
            end else if (event_item.ack_number == last_ack) begin
              duplicate_count <= dup_next;
              window_fixed    <= dup_win;
              if (dup_trigger) begin
                phase_reg <= rcw_pkg::PHASE_RECOVERY;
                threshold <= loss_thr;
                resend    <= 1'b1;
              end
            end else if (event_item.ack_number > last_ack) begin
              remaining       <= event_item.ack_number - last_ack;
              last_ack        <= event_item.ack_number;
              duplicate_count <= 8'd1;
              state           <= ST_LOOP;
            end else begin
              stale_flag <= 1'b1;
            end
          end
        end

        ST_LOOP: begin
          if (remaining == 32'd0) begin
            state <= ST_DONE;
          end else begin
            case (phase_reg)
              rcw_pkg::PHASE_SLOW_START: state <= ST_SS_PLAN;
              rcw_pkg::PHASE_AVOIDANCE: begin
                // The divider starts here on 1.0 / whole window.
                state <= (win_c < MAX_C) ? ST_INC_WAIT : ST_DONE;
              end
              rcw_pkg::PHASE_RECOVERY: begin
                window_fixed <= clamp_win(goal);
                phase_reg    <= rcw_pkg::PHASE_AVOIDANCE;
                state        <= ST_DONE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end

        ST_SS_PLAN: begin
          ss_steps <= ss_pick;
          state    <= ST_SS_APPLY;
        end

        ST_SS_APPLY: begin
          window_fixed <= ss_win;
          remaining    <= remaining - 32'(ss_steps);
          if (CALC_W'(ss_win) >= goal) begin
            phase_reg <= rcw_pkg::PHASE_AVOIDANCE;
            state     <= ST_LOOP;
          end else begin
            state <= ST_DONE;
          end
        end

        ST_INC_WAIT: begin
          if (div_rsp.done) begin
            increment <= rcw_pkg::DIV_DEN_W'(div_rsp.quotient);
            state     <= ST_CA_MUL;
          end
        end

        ST_CA_MUL: begin
          state <= ST_CA_CMP;
        end

        ST_CA_CMP: begin
          if (ca_small) begin
            window_fixed <= ca_win;
            remaining    <= 32'd0;
            state        <= ST_DONE;
          end else begin
            state <= ST_NEED_WAIT;
          end
        end

        ST_NEED_WAIT: begin
          if (div_rsp.done) begin
            need      <= div_rsp.quotient;
            remaining <= remaining - 32'(div_rsp.quotient);
            state     <= ST_NEED_MUL;
          end
        end

        ST_NEED_MUL: begin
          state <= ST_NEED_ADD;
        end

        ST_NEED_ADD: begin
          window_fixed <= ca_win;
          state        <= ST_LOOP;
        end

        ST_DONE: begin
          if (!result_valid || result_ready) begin
            result_item  <= result_next;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // The window stays between one packet and the maximum window.
  assert property (@(posedge clk) disable iff (rst)
    (CALC_W'(window_fixed) >= ONE_C) && (CALC_W'(window_fixed) <= MAX_C))
    else $error("congestion window out of bounds");

  // The divider is never restarted while it is still iterating.
  assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A quotient only arrives while the sequencer waits for one.
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_INC_WAIT) || (state == ST_NEED_WAIT))
    else $error("unexpected divider result");

  // An accepted event drops event_ready in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_ready) |=> !event_ready)
    else $error("event accepted while previous one in progress");

  // A new result is only loaded from the completion state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_DONE))
    else $error("result loaded outside completion");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the Reno congestion window controller.
// Depends on rcw_pkg and reno_congestion_window_top; a built-in window predictor
// checks every result transfer against directed and random ack/timeout traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int          MAX_WINDOW   = 4096;
  localparam logic [63:0] ONE_PKT64    = 64'(rcw_pkg::ONE_PACKET);
  localparam logic [63:0] WINDOW_CEIL  = 64'(MAX_WINDOW) << rcw_pkg::FRAC_W;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          WATCHDOG_NS  = 100_000_000;

  // One event waiting to be offered, with the idle gap that follows its transfer.
  typedef struct {
    rcw_pkg::event_t ev;
    int unsigned     gap;
  } pending_t;

  logic             clk;
  logic             rst          = 1'b1;
  logic             event_valid  = 1'b0;
  logic             event_ready;
  rcw_pkg::event_t  event_item   = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  rcw_pkg::result_t result_item;
  logic             cfg_write    = 1'b0;
  logic             cfg_index    = rcw_pkg::REG_INITIAL_THRESHOLD;
  logic [rcw_pkg::THR_W-1:0] cfg_data = '0;

  reno_congestion_window_top #(
    .MAX_WINDOW(MAX_WINDOW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .event_valid(event_valid),
    .event_ready(event_ready),
    .event_item(event_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_item(result_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // The predictor keeps its own copy of the controller state and registers.
  logic [1:0]                cw_phase;
  logic [32:0]               cw_win;      // congestion window, Q.16
  logic [rcw_pkg::THR_W-1:0] cw_thresh;
  logic [7:0]                dup_run;
  logic [31:0]               acked;
  logic [rcw_pkg::THR_W-1:0] floor_thr;

  pending_t         event_backlog[$];
  rcw_pkg::result_t window_forecast[$];
  logic [31:0]      ack_cursor;       // highest ack offered so far
  int unsigned      gap_left;
  int               mismatches = 0;
  int               results_seen = 0;
  int               stall_left = 0;
  int               rx_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Window predictor
  // ---------------------------------------------------------------------------

  // The window never drops below one packet and never exceeds the ceiling.
  function automatic logic [32:0] bound_window(logic [63:0] w);
    if (w > WINDOW_CEIL) w = WINDOW_CEIL;
    if (w < ONE_PKT64) w = ONE_PKT64;
    return w[32:0];
  endfunction

  // Threshold after a loss: half the whole window, held at the configured floor.
  function automatic logic [rcw_pkg::THR_W-1:0] loss_threshold();
    logic [31:0] h;
    h = 32'(cw_win >> rcw_pkg::FRAC_W) >> 1;
    if (h < 32'(floor_thr)) h = 32'(floor_thr);
    if (h > 32'(rcw_pkg::THRESH_CAP)) h = 32'(rcw_pkg::THRESH_CAP);
    return h[rcw_pkg::THR_W-1:0];
  endfunction

  // Walks the newly acked packets through slow start, avoidance and recovery exit.
  function automatic void absorb_acks(logic [63:0] count);
    logic [63:0] left, goal, need, steps, whole, inc, nxt;
    left = count;
    while (left != 0) begin
      case (cw_phase)
        rcw_pkg::PHASE_SLOW_START: begin
          goal = 64'(cw_thresh) << rcw_pkg::FRAC_W;
          need = 64'd1;
          if (64'(cw_win) < goal)
            need = (goal - 64'(cw_win) + ONE_PKT64 - 64'd1) >> rcw_pkg::FRAC_W;
          steps = (left < need) ? left : need;
          cw_win = bound_window(64'(cw_win) + (steps << rcw_pkg::FRAC_W));
          left = left - steps;
          if (64'(cw_win) >= goal) cw_phase = rcw_pkg::PHASE_AVOIDANCE;
          else left = 0;
        end
        rcw_pkg::PHASE_AVOIDANCE: begin
          if (64'(cw_win) >= WINDOW_CEIL) begin
            left = 0;
          end else begin
            // Each ack adds 1/whole of a packet; jump straight to the next whole packet.
            whole = 64'(cw_win) >> rcw_pkg::FRAC_W;
            inc = ONE_PKT64 / whole;
            nxt = (whole + 64'd1) << rcw_pkg::FRAC_W;
            need = (nxt - 64'(cw_win) + inc - 64'd1) / inc;
            steps = (left < need) ? left : need;
            cw_win = bound_window(64'(cw_win) + steps * inc);
            left = left - steps;
          end
        end
        default: begin
          cw_win = bound_window(64'(cw_thresh) << rcw_pkg::FRAC_W);
          cw_phase = rcw_pkg::PHASE_AVOIDANCE;
          left = 0;
        end
      endcase
    end
  endfunction

  function automatic rcw_pkg::result_t advance_window(rcw_pkg::event_t ev);
    rcw_pkg::result_t r;
    logic             resend, stale_ack;
    logic [31:0]      base, whole;
    resend = 1'b0;
    stale_ack = 1'b0;
    if (ev.operation == rcw_pkg::OP_TIMEOUT) begin
      cw_thresh = loss_threshold();
      cw_win = bound_window(64'(cw_thresh >> 1) << rcw_pkg::FRAC_W);
      dup_run = 8'd1;
      cw_phase = rcw_pkg::PHASE_SLOW_START;
      resend = 1'b1;
    end else if (ev.ack_number == acked) begin
      if (cw_phase == rcw_pkg::PHASE_RECOVERY)
        cw_win = bound_window(64'(cw_win) + ONE_PKT64);
      if (dup_run < rcw_pkg::DUP_CAP) dup_run = dup_run + 8'd1;
      if (cw_phase != rcw_pkg::PHASE_RECOVERY && dup_run == rcw_pkg::DUP_TRIGGER) begin
        cw_phase = rcw_pkg::PHASE_RECOVERY;
        cw_thresh = loss_threshold();
        cw_win = bound_window(64'(cw_win) + 64'd3 * ONE_PKT64);
        resend = 1'b1;
      end
    end else if (ev.ack_number > acked) begin
      absorb_acks(64'(ev.ack_number - acked));
      acked = ev.ack_number;
      dup_run = 8'd1;
    end else begin
      stale_ack = 1'b1;
    end
    base = acked + 32'd1;
    whole = 32'(cw_win >> rcw_pkg::FRAC_W);
    r.window_base = base;
    r.window_end = base + whole - 32'd1;
    r.retransmit = resend;
    r.retransmit_number = resend ? base : 32'd0;
    r.phase = cw_phase;
    r.window_whole = whole[rcw_pkg::THR_W-1:0];
    r.stale = stale_ack;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Queues one event for the driver. A calm event is followed by no idle gap.
  function automatic void offer(logic op, logic [31:0] ack, bit calm);
    pending_t p;
    p.ev.operation = op;
    p.ev.ack_number = ack;
    p.gap = calm ? 0 : pick_gap();
    event_backlog = {event_backlog, p};
    if (op == rcw_pkg::OP_ACK && ack > ack_cursor) ack_cursor = ack;
  endfunction

  // Ack advances are mostly a few packets, sometimes a window's worth.
  function automatic logic [31:0] pick_advance();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 600);
  endfunction

  // Blocks until every queued event has been transferred and answered, then idles.
  task automatic drain(input int unsigned linger);
    while (event_backlog.size() != 0 || event_valid || window_forecast.size() != 0)
      @(negedge clk);
    repeat (linger) @(negedge clk);
  endtask

  // Register writes happen only while the controller is idle, so the predictor
  // copy can be updated right away.
  task automatic write_reg(input logic idx, input logic [rcw_pkg::THR_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == rcw_pkg::REG_INITIAL_THRESHOLD) begin
      cw_thresh = val;
    end else begin
      floor_thr = val;
    end
  endtask

  // One stretch of random traffic. Most of it is well formed: fresh acks that
  // move the window, short duplicate runs that open fast recovery, and recovery
  // rounds closed by a new ack. Timeouts and stale acks are mixed in as noise.
  task automatic random_phase(input int unsigned quota, input bit with_long_run);
    int unsigned made, pick, run, k;
    bit calm;
    made = 0;
    if (with_long_run) begin
      // Enough duplicates in a row to pin the duplicate counter at its ceiling.
      offer(rcw_pkg::OP_ACK, ack_cursor + pick_advance(), 1'b0);
      for (k = 0; k < 258; k++) offer(rcw_pkg::OP_ACK, ack_cursor, 1'b0);
    end
    while (made < quota) begin
      calm = (made % 64) < 12;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        offer(rcw_pkg::OP_ACK, ack_cursor + pick_advance(), calm);
        made++;
      end else if (pick < 70) begin
        run = $urandom_range(1, 5);
        for (k = 0; k < run; k++) offer(rcw_pkg::OP_ACK, ack_cursor, calm);
        made += run;
      end else if (pick < 82) begin
        offer(rcw_pkg::OP_TIMEOUT, $urandom(), calm);
        made++;
      end else if (pick < 95) begin
        if ($urandom_range(0, 1) == 0)
          offer(rcw_pkg::OP_ACK, $urandom_range(0, ack_cursor - 1), calm);
        else
          offer(rcw_pkg::OP_ACK, ack_cursor - $urandom_range(1, 3), calm);
        made++;
      end else begin
        // Full fast recovery round: three duplicates, then the repair ack.
        for (k = 0; k < 3; k++) offer(rcw_pkg::OP_ACK, ack_cursor, calm);
        offer(rcw_pkg::OP_ACK, ack_cursor + $urandom_range(1, 8), calm);
        made += 4;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued events and predicts the result of every transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pending_t         p;
    rcw_pkg::result_t fresh;
    if (rst) begin
      event_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (event_valid && event_ready) begin
        fresh = advance_window(event_item);
        window_forecast = {window_forecast, fresh};
      end
      // The channel is free once the current offer has been taken or none is up.
      if (!event_valid || event_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          event_valid <= 1'b0;
        end else if (event_backlog.size() != 0) begin
          p = event_backlog[0];
          event_backlog.delete(0);
          event_item <= p.ev;
          event_valid <= 1'b1;
          gap_left <= p.gap;
        end else begin
          event_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer and throttles result_ready.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rcw_pkg::result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (result_valid && result_ready) begin
        if (window_forecast.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, result_item);
          mismatches++;
        end else begin
          want = window_forecast[0];
          window_forecast.delete(0);
          compare_field("window_base", want.window_base, result_item.window_base);
          compare_field("window_end", want.window_end, result_item.window_end);
          compare_field("retransmit", 32'(want.retransmit), 32'(result_item.retransmit));
          compare_field("retransmit_number", want.retransmit_number,
                        result_item.retransmit_number);
          compare_field("phase", 32'(want.phase), 32'(result_item.phase));
          compare_field("window_whole", 32'(want.window_whole),
                        32'(result_item.window_whole));
          compare_field("stale", 32'(want.stale), 32'(result_item.stale));
        end
        results_seen++;
        // Now and then hold off for a long time so the controller backs up and
        // stops taking events while the driver keeps offering.
        if (results_seen % 400 == 150) stall_left = HOLD_CYCLES;
      end
      // Random receiver stalls are not started in the first eighth of each rx_cycles period.
      if (stall_left != 0) stall_left--;
      else if (rx_cycles % 4096 >= 512 && $urandom_range(0, 99) < 15)
        stall_left = int'(pick_gap());
      result_ready <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    cw_phase = rcw_pkg::PHASE_SLOW_START;
    cw_win = 33'(ONE_PKT64);
    floor_thr = rcw_pkg::MINIMUM_THRESHOLD_RESET;
    cw_thresh = rcw_pkg::INITIAL_THRESHOLD_RESET;
    dup_run = 8'd1;
    acked = 32'd0;
    ack_cursor = 32'd0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Default registers. Ack zero right after reset is already a duplicate, so
    // two of them open fast recovery from a one-packet window; a third grows it.
    offer(rcw_pkg::OP_ACK, 32'd0, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'd0, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'd0, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'd1, 1'b0);           // leaves recovery at the threshold
    offer(rcw_pkg::OP_ACK, 32'd5, 1'b0);           // fractional growth in avoidance
    offer(rcw_pkg::OP_ACK, 32'd2, 1'b0);           // stale ack
    offer(rcw_pkg::OP_TIMEOUT, 32'd0, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'd10, 1'b0);          // slow start short of the threshold
    offer(rcw_pkg::OP_ACK, 32'd30, 1'b0);          // crosses the threshold mid-ack
    offer(rcw_pkg::OP_TIMEOUT, 32'hFFFF_FFFF, 1'b0);
    drain(8);

    // Smallest thresholds: repeated timeouts drive the window to its one-packet floor.
    write_reg(rcw_pkg::REG_INITIAL_THRESHOLD, 13'd1);
    write_reg(rcw_pkg::REG_MINIMUM_THRESHOLD, 13'd1);
    offer(rcw_pkg::OP_ACK, 32'd31, 1'b0);
    offer(rcw_pkg::OP_TIMEOUT, 32'h5555_AAAA, 1'b0);
    offer(rcw_pkg::OP_TIMEOUT, 32'hAAAA_5555, 1'b0);
    offer(rcw_pkg::OP_TIMEOUT, 32'd0, 1'b0);
    offer(rcw_pkg::OP_TIMEOUT, 32'h0F0F_F0F0, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'd40, 1'b0);
    drain(8);

    // Largest thresholds: a huge ack jump fills the window to its ceiling, then
    // recovery saturates it. The jump also moves acks into the upper half of
    // the number space, so stale acks can carry any lower value from here on.
    write_reg(rcw_pkg::REG_INITIAL_THRESHOLD, 13'd4096);
    write_reg(rcw_pkg::REG_MINIMUM_THRESHOLD, 13'd4096);
    offer(rcw_pkg::OP_TIMEOUT, 32'd0, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'h8000_0000, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'h8000_0001, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'h8000_0001, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'h8000_0001, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'h8000_0001, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'h7FFF_FFFF, 1'b0);
    offer(rcw_pkg::OP_TIMEOUT, 32'h1234_5678, 1'b0);
    drain(8);

    // Random traffic under several register settings.
    write_reg(rcw_pkg::REG_INITIAL_THRESHOLD, 13'($urandom_range(2, 300)));
    write_reg(rcw_pkg::REG_MINIMUM_THRESHOLD, 13'($urandom_range(1, 64)));
    random_phase(190, 1'b0);
    drain(8);
    write_reg(rcw_pkg::REG_INITIAL_THRESHOLD, 13'd4096);
    write_reg(rcw_pkg::REG_MINIMUM_THRESHOLD, 13'd1);
    random_phase(190, 1'b1);
    drain(8);
    write_reg(rcw_pkg::REG_INITIAL_THRESHOLD, 13'd1);
    write_reg(rcw_pkg::REG_MINIMUM_THRESHOLD, 13'd4096);
    random_phase(190, 1'b0);
    drain(8);
    write_reg(rcw_pkg::REG_INITIAL_THRESHOLD, 13'($urandom_range(1, 4096)));
    write_reg(rcw_pkg::REG_MINIMUM_THRESHOLD, 13'($urandom_range(1, 4096)));
    random_phase(190, 1'b0);

    // Top of the ack space, run last because it pins the last ack there: the
    // window base wraps to zero and the window end wraps past it.
    offer(rcw_pkg::OP_TIMEOUT, 32'd0, 1'b0);
    drain(8);
    write_reg(rcw_pkg::REG_INITIAL_THRESHOLD, 13'd4096);
    write_reg(rcw_pkg::REG_MINIMUM_THRESHOLD, 13'd32);
    offer(rcw_pkg::OP_ACK, 32'hFFFF_FFFE, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'hFFFF_FFFF, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'hFFFF_FFFF, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'hFFFF_FFFF, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'hFFFF_FFFF, 1'b0);
    offer(rcw_pkg::OP_ACK, 32'd0, 1'b0);
    offer(rcw_pkg::OP_TIMEOUT, 32'hFFFF_FFFF, 1'b0);

    // Let any stray result surface before the verdict.
    drain(64);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
